@@ rtl/core/fbtr_pkg.sv @@
// Shared types and constants for the page framebuffer text renderer.
// Used by every module under rtl/core but fbtr_store; depends on nothing else.
package fbtr_pkg;

   typedef enum logic [2:0] {
      OP_FILL   = 3'd0,
      OP_PIXEL  = 3'd1,
      OP_CURSOR = 3'd2,
      OP_GLYPH  = 3'd3,
      OP_HEADER = 3'd4,
      OP_READ   = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_CLIP   = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_INVERT      = 2'd0,
      CSR_FONT_WIDTH  = 2'd1,
      CSR_FONT_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FILL,
      S_WALK,
      S_DRAIN,
      S_READ,
      S_HDR_LOW,
      S_HDR_HIGH
   } state_type;

   typedef struct packed {
      logic       invert;
      logic [4:0] font_width;
      logic [6:0] font_height;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_command;
      logic       last;
      status_type status;
   } result_type;

   localparam int         CSR_DATA_W        = 7;
   localparam logic [4:0] FONT_WIDTH_RESET  = 5'd11;
   localparam logic [6:0] FONT_HEIGHT_RESET = 7'd18;
   localparam logic [6:0] MAX_GLYPH_ROWS    = 7'd64;

   localparam logic [7:0]  CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0]  CMD_COL_LOW   = 8'h00;
   localparam logic [7:0]  CMD_COL_HIGH  = 8'h10;
   localparam logic [7:0]  FILL_WHITE    = 8'hFF;
   localparam logic [7:0]  FILL_BLACK    = 8'h00;
   localparam logic [15:0] PIXEL_MARK    = 16'h8000;

endpackage

@@ rtl/core/fbtr_store.sv @@
// Frame store: one write port and one read port, registered read data.
// Depends on nothing; depth and address width come from the instantiating module.
module fbtr_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   // The read data holds until the next read, so a waiting result keeps its byte.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/fbtr_outq.sv @@
// Two-entry result queue between the drawing engine and the rsp_ channel.
// Depends on fbtr_pkg for the result type.
module fbtr_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fbtr_pkg::result_type push_data,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fbtr_pkg::result_type rsp_data
);

   fbtr_pkg::result_type slots_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign room      = (cnt_ff != 2'd2);
   assign rsp_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/fbtr_engine.sv @@
// Drawing engine: transaction sequencer, cursor state and the read-modify-write
// walk over the frame store. Depends on fbtr_pkg.
module fbtr_engine #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64,
   localparam int PAGES = SCREEN_HEIGHT / 8,
   localparam int DEPTH = SCREEN_WIDTH * PAGES,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fbtr_pkg::cfg_type    cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_opcode,
   input  logic [7:0]           req_pos_x,
   input  logic [7:0]           req_pos_y,
   input  logic                 req_color,
   input  logic [15:0]          req_glyph_bits,
   input  logic [2:0]           req_page,
   input  logic [6:0]           req_column,
   input  logic                 q_room,
   output logic                 q_push,
   output fbtr_pkg::result_type q_data,
   output logic                 mem_re,
   output logic [AW-1:0]        mem_raddr,
   input  logic [7:0]           mem_rdata,
   output logic                 mem_we,
   output logic [AW-1:0]        mem_waddr,
   output logic [7:0]           mem_wdata
);

   localparam logic [8:0]    WIDTH_LIM  = 9'(SCREEN_WIDTH);
   localparam logic [8:0]    HEIGHT_LIM = 9'(SCREEN_HEIGHT);
   // Rows that have a byte in the store; a partial last page is not stored.
   localparam logic [8:0]    ROWS_LIM   = 9'(PAGES * 8);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

   fbtr_pkg::state_type state_ff, state_in;

   logic [7:0]           cx_ff, cx_in;
   logic [7:0]           cy_ff, cy_in;
   logic [5:0]           row_ff, row_in;
   logic                 rej_ff, rej_in;
   logic [8:0]           wx_ff, wx_in;
   logic [8:0]           wy_ff, wy_in;
   logic [15:0]          wbits_ff, wbits_in;
   logic                 wclr_ff, wclr_in;
   logic [4:0]           wcnt_ff, wcnt_in;
   logic [4:0]           j_ff, j_in;
   fbtr_pkg::status_type status_ff, status_in;
   logic [AW-1:0]        fill_addr_ff, fill_addr_in;
   logic [7:0]           fill_byte_ff, fill_byte_in;
   logic                 wr_valid_ff, wr_valid_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   logic [2:0]           wr_bit_ff, wr_bit_in;
   logic                 wr_white_ff, wr_white_in;

   logic          accept;
   logic [6:0]    eff_h;
   logic          rej_now;
   logic          glyph_end;
   logic          glyph_draw;
   logic          pix_on_req;
   logic          read_ok;
   logic [AW-1:0] read_addr;
   logic [8:0]    walk_x;
   logic          walk_on;
   logic [AW-1:0] walk_addr;
   logic          walk_bit;
   logic          walk_last;
   logic          fill_last;
   logic [7:0]    wr_mask;

   assign req_ready = (state_ff == fbtr_pkg::S_IDLE) && q_room;
   assign accept    = req_valid && req_ready;

   // Glyph bookkeeping; the space check only counts on the first row.
   always_comb begin
      priority if (cfg.font_height == 7'd0) begin
         eff_h = 7'd1;
      end else if (cfg.font_height > fbtr_pkg::MAX_GLYPH_ROWS) begin
         eff_h = fbtr_pkg::MAX_GLYPH_ROWS;
      end else begin
         eff_h = cfg.font_height;
      end
   end

   assign rej_now = (row_ff == 6'd0)
      ? ((({1'b0, cx_ff} + {4'b0, cfg.font_width}) >= WIDTH_LIM) ||
         (({1'b0, cy_ff} + {2'b0, cfg.font_height}) >= HEIGHT_LIM))
      : rej_ff;
   assign glyph_end  = ({1'b0, row_ff} + 7'd1) >= eff_h;
   assign glyph_draw = !rej_now && (cfg.font_width != 5'd0);

   assign pix_on_req = ({1'b0, req_pos_x} < WIDTH_LIM) && ({1'b0, req_pos_y} < ROWS_LIM);
   assign read_ok    = (int'(req_page) < PAGES) && (int'(req_column) < SCREEN_WIDTH);
   assign read_addr  = AW'(int'(req_page) * SCREEN_WIDTH + int'(req_column));

   assign walk_x    = wx_ff + {4'b0, j_ff};
   assign walk_on   = (walk_x < WIDTH_LIM) && (wy_ff < ROWS_LIM);
   assign walk_addr = AW'(int'(wy_ff[5:3]) * SCREEN_WIDTH + int'(walk_x));
   assign walk_bit  = j_ff[4] ? 1'b0 : wbits_ff[~j_ff[3:0]];
   assign walk_last = ((j_ff + 5'd1) == wcnt_ff);
   assign fill_last = (fill_addr_ff == LAST_ADDR);
   assign wr_mask   = 8'b1 << wr_bit_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbtr_pkg::S_CLEAR: begin
            if (fill_last) state_in = fbtr_pkg::S_IDLE;
         end
         fbtr_pkg::S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  fbtr_pkg::OP_FILL:   state_in = fbtr_pkg::S_FILL;
                  fbtr_pkg::OP_PIXEL:  state_in = pix_on_req ? fbtr_pkg::S_WALK
                                                             : fbtr_pkg::S_IDLE;
                  fbtr_pkg::OP_GLYPH:  state_in = glyph_draw ? fbtr_pkg::S_WALK
                                                             : fbtr_pkg::S_IDLE;
                  fbtr_pkg::OP_HEADER: state_in = fbtr_pkg::S_HDR_LOW;
                  fbtr_pkg::OP_READ:   state_in = read_ok ? fbtr_pkg::S_READ
                                                          : fbtr_pkg::S_IDLE;
                  default:             state_in = fbtr_pkg::S_IDLE;
               endcase
            end
         end
         fbtr_pkg::S_FILL: begin
            if (fill_last) state_in = fbtr_pkg::S_DRAIN;
         end
         fbtr_pkg::S_WALK: begin
            if (walk_last) state_in = fbtr_pkg::S_DRAIN;
         end
         fbtr_pkg::S_DRAIN: begin
            if (q_room) state_in = fbtr_pkg::S_IDLE;
         end
         fbtr_pkg::S_READ: begin
            if (q_room) state_in = fbtr_pkg::S_IDLE;
         end
         fbtr_pkg::S_HDR_LOW: begin
            if (q_room) state_in = fbtr_pkg::S_HDR_HIGH;
         end
         fbtr_pkg::S_HDR_HIGH: begin
            if (q_room) state_in = fbtr_pkg::S_IDLE;
         end
         default: state_in = fbtr_pkg::S_IDLE;
      endcase
   end

   // Outputs: result pushes and memory accesses.
   always_comb begin
      q_push    = 1'b0;
      q_data    = '{out_byte: 8'h00, is_command: 1'b0, last: 1'b1,
                    status: fbtr_pkg::STATUS_DONE};
      mem_re    = 1'b0;
      mem_raddr = walk_addr;
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = wr_white_ff ? (mem_rdata | wr_mask) : (mem_rdata & ~wr_mask);

      unique case (state_ff)
         fbtr_pkg::S_CLEAR, fbtr_pkg::S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_addr_ff;
            mem_wdata = fill_byte_ff;
         end
         fbtr_pkg::S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  fbtr_pkg::OP_PIXEL: begin
                     q_push        = !pix_on_req;
                     q_data.status = fbtr_pkg::STATUS_CLIP;
                  end
                  fbtr_pkg::OP_CURSOR: begin
                     q_push = 1'b1;
                  end
                  fbtr_pkg::OP_GLYPH: begin
                     q_push        = !glyph_draw;
                     q_data.status = rej_now ? fbtr_pkg::STATUS_REJECT
                                             : fbtr_pkg::STATUS_DONE;
                  end
                  fbtr_pkg::OP_HEADER: begin
                     q_push            = 1'b1;
                     q_data.out_byte   = fbtr_pkg::CMD_PAGE_BASE + {5'b0, req_page};
                     q_data.is_command = 1'b1;
                     q_data.last       = 1'b0;
                  end
                  fbtr_pkg::OP_READ: begin
                     q_push        = !read_ok;
                     q_data.status = fbtr_pkg::STATUS_CLIP;
                     mem_re        = read_ok;
                     mem_raddr     = read_addr;
                  end
                  default: begin
                     q_push = 1'b0;
                  end
               endcase
            end
         end
         fbtr_pkg::S_WALK: begin
            mem_re = walk_on;
            mem_we = wr_valid_ff;
         end
         fbtr_pkg::S_DRAIN: begin
            mem_we        = wr_valid_ff;
            q_push        = q_room;
            q_data.status = status_ff;
         end
         fbtr_pkg::S_READ: begin
            q_push          = q_room;
            q_data.out_byte = mem_rdata;
         end
         fbtr_pkg::S_HDR_LOW: begin
            q_push            = q_room;
            q_data.out_byte   = fbtr_pkg::CMD_COL_LOW;
            q_data.is_command = 1'b1;
            q_data.last       = 1'b0;
         end
         fbtr_pkg::S_HDR_HIGH: begin
            q_push            = q_room;
            q_data.out_byte   = fbtr_pkg::CMD_COL_HIGH;
            q_data.is_command = 1'b1;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      row_in       = row_ff;
      rej_in       = rej_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      wbits_in     = wbits_ff;
      wclr_in      = wclr_ff;
      wcnt_in      = wcnt_ff;
      j_in         = j_ff;
      status_in    = status_ff;
      fill_addr_in = fill_addr_ff;
      fill_byte_in = fill_byte_ff;

      // Each on-screen walk step reads one column byte; its write lands in the next cycle.
      wr_valid_in = (state_ff == fbtr_pkg::S_WALK) && walk_on;
      wr_addr_in  = walk_addr;
      wr_bit_in   = wy_ff[2:0];
      wr_white_in = walk_bit ? wclr_ff : ~wclr_ff;

      if (state_ff == fbtr_pkg::S_CLEAR || state_ff == fbtr_pkg::S_FILL) begin
         fill_addr_in = fill_addr_ff + AW'(1);
      end
      if (state_ff == fbtr_pkg::S_WALK) begin
         j_in = j_ff + 5'd1;
      end

      if (accept) begin
         j_in      = 5'd0;
         status_in = fbtr_pkg::STATUS_DONE;
         case (req_opcode)
            fbtr_pkg::OP_FILL: begin
               fill_addr_in = '0;
               fill_byte_in = req_color ? fbtr_pkg::FILL_WHITE : fbtr_pkg::FILL_BLACK;
            end
            fbtr_pkg::OP_PIXEL: begin
               wx_in    = {1'b0, req_pos_x};
               wy_in    = {1'b0, req_pos_y};
               wbits_in = fbtr_pkg::PIXEL_MARK;
               wcnt_in  = 5'd1;
               wclr_in  = req_color ^ cfg.invert;
            end
            fbtr_pkg::OP_CURSOR: begin
               cx_in  = req_pos_x;
               cy_in  = req_pos_y;
               row_in = 6'd0;
               rej_in = 1'b0;
            end
            fbtr_pkg::OP_GLYPH: begin
               wx_in    = {1'b0, cx_ff};
               wy_in    = {1'b0, cy_ff} + {3'b0, row_ff};
               wbits_in = req_glyph_bits;
               wcnt_in  = cfg.font_width;
               wclr_in  = req_color ^ cfg.invert;
               if (glyph_end) begin
                  if (!rej_now) cx_in = cx_ff + {3'b0, cfg.font_width};
                  row_in = 6'd0;
                  rej_in = 1'b0;
               end else begin
                  row_in = row_ff + 6'd1;
                  rej_in = rej_now;
               end
            end
            default: begin
               j_in = 5'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbtr_pkg::S_CLEAR;
         cx_ff        <= 8'd0;
         cy_ff        <= 8'd0;
         row_ff       <= 6'd0;
         rej_ff       <= 1'b0;
         fill_addr_ff <= '0;
         fill_byte_ff <= fbtr_pkg::FILL_BLACK;
         wr_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         row_ff       <= row_in;
         rej_ff       <= rej_in;
         fill_addr_ff <= fill_addr_in;
         fill_byte_ff <= fill_byte_in;
         wr_valid_ff  <= wr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      wbits_ff    <= wbits_in;
      wclr_ff     <= wclr_in;
      wcnt_ff     <= wcnt_in;
      j_ff        <= j_in;
      status_ff   <= status_in;
      wr_addr_ff  <= wr_addr_in;
      wr_bit_ff   <= wr_bit_in;
      wr_white_ff <= wr_white_in;
   end

   // A pending byte write only exists during a walk or its drain.
   a_wr_in_walk: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> (state_ff == fbtr_pkg::S_WALK || state_ff == fbtr_pkg::S_DRAIN))
      else $error("pending write outside a walk");

   a_no_rmw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write of the same byte in one cycle");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_room)
      else $error("result pushed into a full queue");

   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbtr_pkg::S_CLEAR || state_ff == fbtr_pkg::S_FILL) |-> !req_ready)
      else $error("transaction taken during a store sweep");

   a_walk_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbtr_pkg::S_WALK && walk_last) |=> (state_ff == fbtr_pkg::S_DRAIN))
      else $error("walk did not end in drain");

endmodule

@@ rtl/core/page_framebuffer_text_renderer_top.sv @@
// Top level of the page framebuffer text renderer: configuration registers,
// frame store, drawing engine and result queue. Depends on fbtr_pkg and all rtl/core modules.
//
//   channel | ports      | handshake            | carries
//   --------+------------+----------------------+------------------------------------
//   request | req_*      | req_valid/req_ready  | opcode, position, color, glyph row, page, column
//   result  | rsp_*      | rsp_valid/rsp_ready  | byte, command flag, last, status
//   config  | csr_*      | csr_we, no wait      | invert, font width, font height
//
// After reset a clearing pass writes every store byte while no request is taken; config
// writes are accepted. Cursor, clipped pixel, rejected or empty glyph row and
// out-of-range read push their result from the idle state. Pixel and drawn glyph row
// write one store byte per cycle through the single read-modify-write path, then push
// their result. Fill walks the whole store, one byte per cycle.
// A two-entry result queue lets a new transaction start while a result waits.
module page_framebuffer_text_renderer_top #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_opcode,
   input  logic [7:0]                    req_pos_x,
   input  logic [7:0]                    req_pos_y,
   input  logic                          req_color,
   input  logic [15:0]                   req_glyph_bits,
   input  logic [2:0]                    req_page,
   input  logic [6:0]                    req_column,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_is_command,
   output logic                          rsp_last,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [fbtr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int PAGES = SCREEN_HEIGHT / 8;
   localparam int DEPTH = SCREEN_WIDTH * PAGES;
   localparam int AW    = $clog2(DEPTH);

   fbtr_pkg::cfg_type    cfg_ff, cfg_in;
   fbtr_pkg::result_type q_data;
   fbtr_pkg::result_type rsp_data;
   logic                 q_push;
   logic                 q_room;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;
   logic [7:0]           mem_rdata;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [7:0]           mem_wdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            fbtr_pkg::CSR_INVERT:      cfg_in.invert      = csr_wdata[0];
            fbtr_pkg::CSR_FONT_WIDTH:  cfg_in.font_width  = csr_wdata[4:0];
            fbtr_pkg::CSR_FONT_HEIGHT: cfg_in.font_height = csr_wdata[6:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{invert: 1'b0,
                     font_width: fbtr_pkg::FONT_WIDTH_RESET,
                     font_height: fbtr_pkg::FONT_HEIGHT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbtr_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata)
   );

   fbtr_engine #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_color      (req_color),
      .req_glyph_bits (req_glyph_bits),
      .req_page       (req_page),
      .req_column     (req_column),
      .q_room         (q_room),
      .q_push         (q_push),
      .q_data         (q_data),
      .mem_re         (mem_re),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata)
   );

   fbtr_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .room      (q_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte   = rsp_data.out_byte;
   assign rsp_is_command = rsp_data.is_command;
   assign rsp_last       = rsp_data.last;
   assign rsp_status     = rsp_data.status;

endmodule

@@ sim/frame_render_checker.sv @@
// Checker for the page framebuffer text renderer: watches the request, result and
// register ports, keeps a shadow frame store, cursor and registers, and compares results.
// Depends on fbtr_pkg.
module frame_render_checker #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [2:0]                      req_opcode,
   input  logic [7:0]                      req_pos_x,
   input  logic [7:0]                      req_pos_y,
   input  logic                            req_color,
   input  logic [15:0]                     req_glyph_bits,
   input  logic [2:0]                      req_page,
   input  logic [6:0]                      req_column,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [7:0]                      rsp_out_byte,
   input  logic                            rsp_is_command,
   input  logic                            rsp_last,
   input  logic [1:0]                      rsp_status,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [fbtr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending_replies,
   output int                              checked_replies
);

   localparam int STORE_DEPTH = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);

   logic [7:0]           shadow_store [STORE_DEPTH];
   logic [7:0]           cursor_x;
   logic [7:0]           cursor_y;
   logic [5:0]           row_index;
   logic                 glyph_dropped;
   fbtr_pkg::cfg_type    cfg;
   fbtr_pkg::result_type reply_q [$];

   // Returns 1 when the pixel lies on the screen and was written.
   function automatic bit paint(int x, int y, logic white);
      int addr;
      if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return 1'b0;
      addr = x + (y / 8) * SCREEN_WIDTH;
      // Rows of a partial last page have no byte in the store.
      if (addr >= STORE_DEPTH) return 1'b0;
      if (cfg.invert) white = ~white;
      shadow_store[addr][y % 8] = white;
      return 1'b1;
   endfunction

   function automatic void push_reply(logic [7:0] data, logic cmd, logic fin,
                                      fbtr_pkg::status_type st);
      fbtr_pkg::result_type r;
      r.out_byte   = data;
      r.is_command = cmd;
      r.last       = fin;
      r.status     = st;
      reply_q.push_back(r);
   endfunction

   function automatic void predict_request();
      int                   rows;
      int                   cx;
      int                   cy;
      int                   ri;
      logic                 on;
      fbtr_pkg::status_type st;
      cx = cursor_x;
      cy = cursor_y;
      ri = row_index;
      st = fbtr_pkg::STATUS_DONE;
      case (req_opcode)
         fbtr_pkg::OP_FILL: begin
            foreach (shadow_store[i])
               shadow_store[i] = req_color ? fbtr_pkg::FILL_WHITE : fbtr_pkg::FILL_BLACK;
            push_reply(8'h00, 1'b0, 1'b1, fbtr_pkg::STATUS_DONE);
         end
         fbtr_pkg::OP_PIXEL: begin
            if (!paint(req_pos_x, req_pos_y, req_color)) st = fbtr_pkg::STATUS_CLIP;
            push_reply(8'h00, 1'b0, 1'b1, st);
         end
         fbtr_pkg::OP_CURSOR: begin
            cursor_x      = req_pos_x;
            cursor_y      = req_pos_y;
            row_index     = '0;
            glyph_dropped = 1'b0;
            push_reply(8'h00, 1'b0, 1'b1, fbtr_pkg::STATUS_DONE);
         end
         fbtr_pkg::OP_GLYPH: begin
            rows = cfg.font_height;
            if (rows < 1) rows = 1;
            if (rows > fbtr_pkg::MAX_GLYPH_ROWS) rows = fbtr_pkg::MAX_GLYPH_ROWS;
            // The space check is made only on the first row of a glyph.
            if (ri == 0)
               glyph_dropped = (cx + cfg.font_width >= SCREEN_WIDTH) ||
                               (cy + cfg.font_height >= SCREEN_HEIGHT);
            if (!glyph_dropped) begin
               for (int j = 0; j < cfg.font_width; j++) begin
                  on = (j < 16) ? req_glyph_bits[15 - j] : 1'b0;
                  void'(paint(cx + j, cy + ri, on ? req_color : ~req_color));
               end
            end
            if (glyph_dropped) st = fbtr_pkg::STATUS_REJECT;
            if (ri + 1 >= rows) begin
               if (!glyph_dropped) cursor_x = cursor_x + cfg.font_width;
               row_index     = '0;
               glyph_dropped = 1'b0;
            end else begin
               row_index = row_index + 1'b1;
            end
            push_reply(8'h00, 1'b0, 1'b1, st);
         end
         fbtr_pkg::OP_HEADER: begin
            push_reply(fbtr_pkg::CMD_PAGE_BASE + req_page, 1'b1, 1'b0,
                       fbtr_pkg::STATUS_DONE);
            push_reply(fbtr_pkg::CMD_COL_LOW, 1'b1, 1'b0, fbtr_pkg::STATUS_DONE);
            push_reply(fbtr_pkg::CMD_COL_HIGH, 1'b1, 1'b1, fbtr_pkg::STATUS_DONE);
         end
         fbtr_pkg::OP_READ: begin
            if (req_page < SCREEN_HEIGHT / 8 && req_column < SCREEN_WIDTH)
               push_reply(shadow_store[req_page * SCREEN_WIDTH + req_column], 1'b0, 1'b1,
                          fbtr_pkg::STATUS_DONE);
            else
               push_reply(8'h00, 1'b0, 1'b1, fbtr_pkg::STATUS_CLIP);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_reply();
      fbtr_pkg::result_type want;
      if (reply_q.size() == 0) begin
         $error("result transaction with nothing expected: out_byte %h status %0d",
                rsp_out_byte, rsp_status);
         fail_count++;
         return;
      end
      want = reply_q.pop_front();
      checked_replies++;
      if (rsp_out_byte !== want.out_byte) begin
         $error("out_byte: expected %h, actual %h", want.out_byte, rsp_out_byte);
         fail_count++;
      end
      if (rsp_is_command !== want.is_command) begin
         $error("is_command: expected %b, actual %b", want.is_command, rsp_is_command);
         fail_count++;
      end
      if (rsp_last !== want.last) begin
         $error("last: expected %b, actual %b", want.last, rsp_last);
         fail_count++;
      end
      if (rsp_status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, rsp_status);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_store[i]) shadow_store[i] = 8'h00;
         cursor_x         = '0;
         cursor_y         = '0;
         row_index        = '0;
         glyph_dropped    = 1'b0;
         cfg.invert       = 1'b0;
         cfg.font_width   = fbtr_pkg::FONT_WIDTH_RESET;
         cfg.font_height  = fbtr_pkg::FONT_HEIGHT_RESET;
         reply_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_reply();
         if (req_valid && req_ready) predict_request();
         if (csr_we) begin
            case (csr_index)
               fbtr_pkg::CSR_INVERT:      cfg.invert      = csr_wdata[0];
               fbtr_pkg::CSR_FONT_WIDTH:  cfg.font_width  = csr_wdata[4:0];
               fbtr_pkg::CSR_FONT_HEIGHT: cfg.font_height = csr_wdata[6:0];
               default: ;
            endcase
         end
      end
      pending_replies = reply_q.size();
   end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the page framebuffer text renderer: clock, reset, request and
// register stimulus, result back-pressure, watchdog and verdict.
// Depends on fbtr_pkg, page_framebuffer_text_renderer_top and frame_render_checker.
module tb_top;

   localparam int SCREEN_WIDTH    = 128;
   localparam int SCREEN_HEIGHT   = 64;
   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 8;
   localparam int END_CYCLES      = 20;
   localparam int WATCHDOG_LIMIT  = 6000;
   localparam int HOLD_CYCLES     = 300;
   localparam int MAX_GAP         = 12;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 46;

   // Opcodes the block ignores.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   localparam int PHASE_INVERT [NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};
   localparam int PHASE_WIDTH  [NUM_PHASES] = '{8, 16, 1, 0, 31, 20, 11, 5};
   localparam int PHASE_HEIGHT [NUM_PHASES] = '{8, 1, 63, 0, 127, 5, 18, 64};

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  pos_x;
      logic [7:0]  pos_y;
      logic        color;
      logic [15:0] glyph_bits;
      logic [2:0]  page;
      logic [6:0]  column;
   } draw_cmd_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [2:0]                      req_opcode;
   logic [7:0]                      req_pos_x;
   logic [7:0]                      req_pos_y;
   logic                            req_color;
   logic [15:0]                     req_glyph_bits;
   logic [2:0]                      req_page;
   logic [6:0]                      req_column;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [7:0]                      rsp_out_byte;
   logic                            rsp_is_command;
   logic                            rsp_last;
   logic [1:0]                      rsp_status;
   logic                            csr_we;
   logic [1:0]                      csr_index;
   logic [fbtr_pkg::CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending_replies;
   int checked_replies;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_requests      = 0;
   int sent_count         = 0;
   int ignored_count      = 0;
   int cur_fw             = fbtr_pkg::FONT_WIDTH_RESET;
   int cur_fh             = fbtr_pkg::FONT_HEIGHT_RESET;
   int quiet_cycles       = 0;

   always #HALF_PERIOD clock = ~clock;

   page_framebuffer_text_renderer_top #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_color     (req_color),
      .req_glyph_bits(req_glyph_bits),
      .req_page      (req_page),
      .req_column    (req_column),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_command(rsp_is_command),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   frame_render_checker #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) frame_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_color      (req_color),
      .req_glyph_bits (req_glyph_bits),
      .req_page       (req_page),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_command (rsp_is_command),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_replies(pending_replies),
      .checked_replies(checked_replies)
   );

   function automatic draw_cmd_type make_cmd(int op, int x, int y, int col, int bits,
                                             int pg, int cl);
      draw_cmd_type c;
      c.opcode     = 3'(op);
      c.pos_x      = 8'(x);
      c.pos_y      = 8'(y);
      c.color      = 1'(col);
      c.glyph_bits = 16'(bits);
      c.page       = 3'(pg);
      c.column     = 7'(cl);
      return c;
   endfunction

   function automatic draw_cmd_type random_cmd(logic [2:0] op);
      return make_cmd(op, $urandom_range(255), $urandom_range(255), $urandom_range(1),
                      $urandom_range(16'hFFFF), $urandom_range(7), $urandom_range(127));
   endfunction

   // Offers one transaction after a random idle gap and returns once it is accepted.
   task automatic send(draw_cmd_type c);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= c.opcode;
      req_pos_x      <= c.pos_x;
      req_pos_y      <= c.pos_y;
      req_color      <= c.color;
      req_glyph_bits <= c.glyph_bits;
      req_page       <= c.page;
      req_column     <= c.column;
      do @(posedge clock); while (!req_ready);
      if (c.opcode == OP_SPARE_A || c.opcode == OP_SPARE_B) ignored_count++;
      else sent_count++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies != 0) @(negedge clock);
   endtask

   task automatic write_config(int inv, int fw, int fh);
      wait_drained();
      // Wait with no traffic before the register writes.
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= fbtr_pkg::CSR_INVERT;
      csr_wdata <= fbtr_pkg::CSR_DATA_W'(inv);
      @(negedge clock);
      csr_index <= fbtr_pkg::CSR_FONT_WIDTH;
      csr_wdata <= fbtr_pkg::CSR_DATA_W'(fw);
      @(negedge clock);
      csr_index <= fbtr_pkg::CSR_FONT_HEIGHT;
      csr_wdata <= fbtr_pkg::CSR_DATA_W'(fh);
      @(negedge clock);
      csr_we <= 1'b0;
      cur_fw = fw;
      cur_fh = fh;
   endtask

   // A cursor placement, one glyph (sometimes cut short), then reads of its columns.
   task automatic glyph_sequence();
      draw_cmd_type c;
      int           rows;
      int           x;
      int           y;
      int           hi;
      rows = cur_fh;
      if (rows < 1) rows = 1;
      if (rows > fbtr_pkg::MAX_GLYPH_ROWS) rows = fbtr_pkg::MAX_GLYPH_ROWS;
      if ($urandom_range(9) == 0) rows = $urandom_range(1, rows);
      if ($urandom_range(9) == 0) begin
         x = $urandom_range(255);
         y = $urandom_range(255);
      end else begin
         x  = $urandom_range(SCREEN_WIDTH + 1 - cur_fw);
         hi = SCREEN_HEIGHT + 1 - cur_fh;
         if (hi < 0) hi = SCREEN_HEIGHT - 1;
         y = $urandom_range(hi);
      end
      c       = random_cmd(fbtr_pkg::OP_CURSOR);
      c.pos_x = 8'(x);
      c.pos_y = 8'(y);
      send(c);
      for (int r = 0; r < rows; r++) send(random_cmd(fbtr_pkg::OP_GLYPH));
      repeat (2) begin
         c        = random_cmd(fbtr_pkg::OP_READ);
         c.page   = 3'((y / 8) % 8);
         c.column = 7'((x + $urandom_range(cur_fw)) % SCREEN_WIDTH);
         send(c);
      end
   endtask

   task automatic random_action();
      draw_cmd_type c;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         glyph_sequence();
      end else if (pick < 65) begin
         c = random_cmd(fbtr_pkg::OP_PIXEL);
         if ($urandom_range(9) != 0) begin
            c.pos_x = 8'($urandom_range(SCREEN_WIDTH + 2));
            c.pos_y = 8'($urandom_range(SCREEN_HEIGHT + 2));
         end
         send(c);
      end else if (pick < 84) begin
         send(random_cmd(fbtr_pkg::OP_READ));
      end else if (pick < 91) begin
         send(random_cmd(fbtr_pkg::OP_HEADER));
      end else if (pick < 93) begin
         send(random_cmd(fbtr_pkg::OP_FILL));
      end else if (pick < 97) begin
         send(random_cmd(fbtr_pkg::OP_GLYPH));
      end else if (pick < 98) begin
         send(random_cmd(fbtr_pkg::OP_CURSOR));
      end else begin
         send(random_cmd($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B));
      end
   endtask

   task automatic directed_checks();
      send(make_cmd(fbtr_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_PIXEL, 0, 0, 1, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_PIXEL, 127, 63, 1, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_PIXEL, 128, 5, 1, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_PIXEL, 3, 64, 1, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_PIXEL, 255, 255, 0, 16'hFFFF, 7, 127));
      send(make_cmd(fbtr_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_READ, 0, 0, 0, 0, 7, 127));
      send(make_cmd(fbtr_pkg::OP_HEADER, 0, 0, 0, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_HEADER, 0, 0, 0, 0, 7, 0));
      send(make_cmd(OP_SPARE_A, 0, 0, 0, 0, 0, 0));
      send(make_cmd(OP_SPARE_B, 0, 0, 0, 0, 0, 0));
      // A glyph that would touch the right edge, then one that would touch the bottom.
      send(make_cmd(fbtr_pkg::OP_CURSOR, 117, 0, 0, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_GLYPH, 0, 0, 1, 16'hFFFF, 0, 0));
      send(make_cmd(fbtr_pkg::OP_CURSOR, 116, 46, 0, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_GLYPH, 0, 0, 1, 16'hFFFF, 0, 0));
      // This glyph is left unfinished, so the next registers apply in its middle.
      send(make_cmd(fbtr_pkg::OP_CURSOR, 0, 0, 0, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_GLYPH, 0, 0, 1, 16'hA5A5, 0, 0));
      send(make_cmd(fbtr_pkg::OP_GLYPH, 0, 0, 0, 16'h8001, 0, 0));
      send(make_cmd(fbtr_pkg::OP_READ, 0, 0, 0, 0, 0, 2));
      send(make_cmd(fbtr_pkg::OP_FILL, 0, 0, 1, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_READ, 0, 0, 0, 0, 3, 64));
      send(make_cmd(fbtr_pkg::OP_FILL, 0, 0, 0, 0, 0, 0));
      send(make_cmd(fbtr_pkg::OP_READ, 0, 0, 0, 0, 3, 64));
   endtask

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_replies);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int  target;
      bit  held;
      bit  paused;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = fbtr_pkg::OP_FILL;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_color      = 1'b0;
      req_glyph_bits = '0;
      req_page       = '0;
      req_column     = '0;
      csr_we         = 1'b0;
      csr_index      = fbtr_pkg::CSR_INVERT;
      csr_wdata      = '0;
      held           = 1'b0;
      paused         = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      directed_checks();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_config(PHASE_INVERT[p], PHASE_WIDTH[p], PHASE_HEIGHT[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         target = sent_count + ITEMS_PER_PHASE;
         while (sent_count < target) begin
            // Halfway through the first phase, stall the result side to fill the block; halfway
            // through the second, let everything drain before going on.
            if (p == 0 && !held && sent_count + ITEMS_PER_PHASE / 2 > target) begin
               hold_requests++;
               held = 1'b1;
            end
            if (p == 1 && !paused && sent_count + ITEMS_PER_PHASE / 2 > target) begin
               wait_drained();
               paused = 1'b1;
            end
            random_action();
         end
      end

      wait_drained();
      repeat (END_CYCLES) @(negedge clock);
      $display("Covered %0d requests and %0d ignored opcodes, %0d results checked,",
               sent_count, ignored_count, checked_replies);
      $display("over the reset registers and %0d further register settings.", NUM_PHASES);
      if (fail_count == 0 && pending_replies == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
